### design/sha224_pkg.sv
// Package with SHA-224 constants, types and a rotate helper function.
`timescale 1ns / 1ps
`default_nettype none
package sha224_pkg;
   localparam int DigestWords = 7;
   localparam int BlockWords = 16;
   localparam int Rounds = 64;

   typedef logic [31:0] word_type;

   typedef enum logic [2:0] {
      WSRC_DATA = 3'b001,
      WSRC_ZERO = 3'b010,
      WSRC_LEN  = 3'b100
   } wsrc_type;

   typedef struct packed {
      logic     push;
      logic     flush;
      logic     pad_push;
      wsrc_type pad_src;
      logic     len_hi;
      logic     start;
      logic     round;
      logic     finish;
      logic     clear;
   } cmd_type;

   typedef struct packed {
      logic       pos_last;
      logic       word_fits;
      logic       flush_fits;
      logic       has_partial;
      logic [3:0] position;
      logic       round_last;
   } status_type;

   localparam word_type InitHash [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

   localparam word_type RoundConst [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction
endpackage
`default_nettype wire

### design/sha224_if.sv
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps
`default_nettype none
interface sha224_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [5:0]  valid_bits;
   logic        final_word;
   modport source (output valid, data_word, valid_bits, final_word, input ready);
   modport sink (input valid, data_word, valid_bits, final_word, output ready);
endinterface

interface sha224_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_result;
   modport source (output valid, digest_word, word_index, last_result, input ready);
   modport sink (input valid, digest_word, word_index, last_result, output ready);
endinterface
`default_nettype wire

### design/sha224_hash_core.sv
// SHA-224 hash core top level.
// Each item is taken in the idle state; an item that completes a block starts its compression.
// A final item adds the padding steps and at most two compressions in all.
// The seven digest items then follow, one a cycle while the sink is ready.
// Sixteen full-width items fill a block; no new item is taken while a block is compressed.
// Synchronous reset loads the SHA-224 initial values and empties the packer.
`timescale 1ns / 1ps
`default_nettype none
module sha224_hash_core
   import sha224_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   sha224_req_if.sink req,
   sha224_rsp_if.source rsp
);
   cmd_type    cmd;
   status_type status;
   logic [2:0] idx;
   logic       last;
   word_type   word;

   sha224_control u_control (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_final(req.final_word),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_index(idx), .out_last(last),
      .cmd(cmd), .status(status));

   sha224_datapath u_datapath (
      .clock(clock), .reset(reset),
      .data_word(req.data_word), .valid_bits(req.valid_bits),
      .cmd(cmd), .status(status),
      .out_index(idx), .out_word(word));

   assign rsp.digest_word = word;
   assign rsp.word_index = idx;
   assign rsp.last_result = last;
endmodule
`default_nettype wire

### design/sha224_datapath.sv
// Bit packer, block store, message schedule and compression round datapath.
`timescale 1ns / 1ps
`default_nettype none
module sha224_datapath
   import sha224_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [31:0] data_word,
   input  wire logic [5:0] valid_bits,
   input  wire cmd_type    cmd,
   output status_type      status,
   input  wire logic [2:0] out_index,
   output word_type        out_word
);
   word_type    chain_ff [8];
   word_type    chain_in [8];
   word_type    sched_ff [16];
   word_type    vars_ff [8];
   logic [63:0] len_ff;
   word_type    part_ff;
   logic [5:0]  fill_ff;
   logic [3:0]  pos_ff;
   logic [5:0]  round_ff;

   logic [5:0]  lim_bits;
   logic [5:0]  nbits;
   logic [63:0] acc;
   logic [63:0] mask;
   logic [6:0]  total;
   logic        do_push;
   word_type    push_word;
   logic [5:0]  add_bits;
   word_type    w_cur, s0, s1, t1, t2, w_new;
   word_type    wa, we;

   always_comb begin
      lim_bits = (valid_bits > 6'd32) ? 6'd32 : valid_bits;
      nbits = lim_bits;
      if (cmd.flush) begin
         nbits = 6'd1;
      end
      mask = (64'hFFFFFFFF << (7'd32 - {1'b0, nbits})) & 64'hFFFFFFFF;
      acc = {part_ff, 32'h0} |
            ((({32'h0, (cmd.flush ? 32'h80000000 : data_word)} & mask)) << (7'd32 - {1'b0, fill_ff}));
      total = {1'b0, fill_ff} + {1'b0, nbits};
      add_bits = cmd.flush ? 6'd0 : nbits;
      do_push = 1'b0;
      push_word = acc[63:32];
      if (cmd.push && nbits != 6'd0 && total >= 7'd32) begin
         do_push = 1'b1;
      end
      if (cmd.pad_push) begin
         do_push = 1'b1;
         unique case (cmd.pad_src)
            WSRC_DATA: push_word = part_ff;
            WSRC_ZERO: push_word = 32'h0;
            WSRC_LEN:  push_word = cmd.len_hi ? len_ff[63:32] : len_ff[31:0];
            default:   push_word = 32'h0;
         endcase
      end
   end

   assign wa = vars_ff[0];
   assign we = vars_ff[4];
   assign s0 = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
   assign s1 = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
   assign w_cur = sched_ff[0];
   assign w_new = sched_ff[0] + s0 + sched_ff[9] + s1;
   assign t1 = vars_ff[7] + (rotr(we, 6) ^ rotr(we, 11) ^ rotr(we, 25))
             + ((we & vars_ff[5]) ^ (~we & vars_ff[6])) + RoundConst[round_ff] + w_cur;
   assign t2 = (rotr(wa, 2) ^ rotr(wa, 13) ^ rotr(wa, 22))
             + ((wa & vars_ff[1]) ^ (wa & vars_ff[2]) ^ (vars_ff[1] & vars_ff[2]));

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         chain_in[i] = chain_ff[i] + vars_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= InitHash[i];
         len_ff <= '0;
         part_ff <= '0;
         fill_ff <= '0;
         pos_ff <= '0;
         round_ff <= '0;
      end else begin
         if (cmd.push) begin
            len_ff <= len_ff + {58'h0, add_bits};
            if (nbits != 6'd0) begin
               if (total >= 7'd32) begin
                  part_ff <= acc[31:0];
                  fill_ff <= 6'(total - 7'd32);
               end else begin
                  part_ff <= acc[63:32];
                  fill_ff <= total[5:0];
               end
            end
         end
         if (cmd.pad_push && cmd.pad_src == WSRC_DATA) begin
            part_ff <= '0;
            fill_ff <= '0;
         end
         if (do_push) begin
            pos_ff <= pos_ff + 4'd1;
         end
         if (cmd.start) begin
            for (int i = 0; i < 8; i++) vars_ff[i] <= chain_ff[i];
            round_ff <= '0;
         end
         if (cmd.round) begin
            vars_ff[7] <= vars_ff[6];
            vars_ff[6] <= vars_ff[5];
            vars_ff[5] <= vars_ff[4];
            vars_ff[4] <= vars_ff[3] + t1;
            vars_ff[3] <= vars_ff[2];
            vars_ff[2] <= vars_ff[1];
            vars_ff[1] <= vars_ff[0];
            vars_ff[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) sched_ff[i] <= sched_ff[i + 1];
            sched_ff[15] <= w_new;
            round_ff <= round_ff + 6'd1;
         end
         if (cmd.finish) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_in[i];
         end
      end
      if (do_push && !reset && !cmd.clear) begin
         sched_ff[pos_ff] <= push_word;
      end
   end

   always_comb begin
      status.pos_last = pos_ff == 4'd15;
      status.word_fits = lim_bits != 6'd0 &&
                         ({1'b0, fill_ff} + {1'b0, lim_bits}) >= 7'd32;
      status.flush_fits = fill_ff == 6'd31;
      status.has_partial = fill_ff != 6'd0;
      status.position = pos_ff;
      status.round_last = round_ff == 6'(Rounds - 1);
   end

   assign out_word = chain_ff[out_index];
endmodule
`default_nettype wire

### design/sha224_control.sv
// Controller state machine sequencing packing, padding, rounds and output.
`timescale 1ns / 1ps
`default_nettype none
module sha224_control
   import sha224_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic       in_final,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [2:0]      out_index,
   output logic            out_last,
   output cmd_type         cmd,
   input  wire status_type status
);
   typedef enum logic [7:0] {
      S_IDLE   = 8'b00000001,
      S_FLUSH  = 8'b00000010,
      S_PART   = 8'b00000100,
      S_PAD    = 8'b00001000,
      S_START  = 8'b00010000,
      S_ROUND  = 8'b00100000,
      S_FINISH = 8'b01000000,
      S_OUT    = 8'b10000000
   } state_type;

   state_type  state_ff, state_in;
   state_type  resume_ff, resume_in;
   logic       hi_ff, hi_in;
   logic [2:0] idx_ff, idx_in;
   logic       accept;

   assign in_ready = state_ff == S_IDLE;
   assign accept = in_valid && in_ready;
   assign out_valid = state_ff == S_OUT;
   assign out_index = idx_ff;
   assign out_last = idx_ff == 3'(DigestWords - 1);

   always_comb begin
      cmd = '0;
      cmd.pad_src = WSRC_ZERO;
      state_in = state_ff;
      resume_in = resume_ff;
      hi_in = hi_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.push = 1'b1;
               if (status.pos_last && status.word_fits) begin
                  resume_in = in_final ? S_FLUSH : S_IDLE;
                  state_in = S_START;
               end else if (in_final) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            cmd.push = 1'b1;
            cmd.flush = 1'b1;
            if (status.pos_last && status.flush_fits) begin
               resume_in = S_PART;
               state_in = S_START;
            end else begin
               state_in = S_PART;
            end
         end
         S_PART: begin
            if (status.has_partial) begin
               cmd.pad_push = 1'b1;
               cmd.pad_src = WSRC_DATA;
            end
            if (status.has_partial && status.pos_last) begin
               resume_in = S_PAD;
               state_in = S_START;
            end else begin
               state_in = S_PAD;
            end
         end
         S_PAD: begin
            cmd.pad_push = 1'b1;
            if (status.position == 4'(BlockWords - 2)) begin
               cmd.pad_src = WSRC_LEN;
               cmd.len_hi = 1'b1;
               hi_in = 1'b1;
            end else if (status.pos_last && hi_ff) begin
               cmd.pad_src = WSRC_LEN;
            end
            if (status.pos_last) begin
               resume_in = hi_ff ? S_OUT : S_PAD;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            if (status.round_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in = resume_ff;
         end
         S_OUT: begin
            if (out_ready) begin
               idx_in = idx_ff + 3'd1;
               if (out_last) begin
                  idx_in = '0;
                  hi_in = 1'b0;
                  cmd.clear = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         resume_ff <= S_IDLE;
         hi_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         resume_ff <= resume_in;
         hi_ff <= hi_in;
         idx_ff <= idx_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_index))
      else $error("response item dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      cmd.round |-> !in_ready)
      else $error("input accepted during compression");
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> out_last && out_ready)
      else $error("state cleared before the last digest item");
endmodule
`default_nettype wire
